### src/ssc_pkg.sv
// Shared types and constants for the serial speed command parser.
// No dependencies; used by the top level and the port checker.
`default_nettype none
package ssc_pkg;

  // Widths of the item fields.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NUM_W    = 11;  // digit run value, saturating
  localparam int unsigned PROD_W   = 15;  // room for 2047 * 10 + 9
  localparam int unsigned HIST_W   = 40;  // last five characters
  localparam int unsigned OUT_TDATA_W = 16;

  localparam int unsigned FRAME_BYTES_DEF = 64;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 10'd1000;
  localparam logic [NUM_W-1:0]  NUM_SAT        = 11'd2047;

  // Keywords, last character in the low byte.
  localparam logic [31:0] KEY_STOP  = 32'h53544F50;  // "STOP"
  localparam logic [23:0] KEY_DUR   = 24'h445552;    // "DUR"
  localparam logic [39:0] KEY_SPEED = 40'h5350454544; // "SPEED"
  localparam logic [23:0] KEY_HIZ   = 24'h48495A;    // "HIZ"

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;   // '0'
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;   // '9'

  typedef enum logic [STATUS_W-1:0] {
    ST_STOPPED   = 2'd0,
    ST_SPEED_SET = 2'd1,
    ST_OUT_RANGE = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NP_NONE = 2'd0,
    NP_RUN  = 2'd1,
    NP_DONE = 2'd2
  } num_phase_t;

endpackage
`default_nettype wire

### src/serial_speed_command_parser_top.sv
// Serial speed command parser, top level.
// Depends on ssc_pkg (constants, status and number phase types).
//
// Channel   Dir  Ports                          Contents
// in_       in   tvalid/tready/tdata/tlast      data_byte in tdata, end_of_frame in tlast
// out_      out  tvalid/tready/tdata            status, duty (one item per frame end)
// cfg_      in   wr_en/wr_data                  duty_limit
//
// Flow: an accepted item is scanned from the input register in the next cycle; the
// scan logic is a keyword compare and a multiply by ten between the input register
// and the frame/result registers. A frame-ending item's result is registered as the
// item leaves the input register. One item per cycle unless a held result stalls it.
// Stalls: a held result only blocks a frame-ending item; other items keep flowing.
// Reset: synchronous rst_n clears frame state, duty to 0, duty_limit to 1000.
`default_nettype none
module serial_speed_command_parser_top #(
  parameter int unsigned FRAME_BYTES = ssc_pkg::FRAME_BYTES_DEF  // 8..256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_frame
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [1:0] status, [11:2] duty, [15:12] zero
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data  // duty_limit
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  // ---------------- configuration ----------------
  logic [ssc_pkg::DUTY_W-1:0] duty_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_limit_r <= ssc_pkg::DUTY_LIMIT_RST;
    end else if (cfg_wr_en) begin
      duty_limit_r <= cfg_wr_data;
    end
  end

  // ---------------- input register ----------------
  logic                       s1_valid_r;
  logic [ssc_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_eof_r;
  logic                       s1_fire;

  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eof_r  <= in_tlast;
    end
  end

  // ---------------- frame state ----------------
  logic [ssc_pkg::HIST_W-1:0] recent_r, recent_nxt;
  logic                       stop_r, stop_nxt;
  logic                       speed_r, speed_nxt;
  ssc_pkg::num_phase_t        phase_r, phase_nxt;
  logic [ssc_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic                       term_r, term_nxt;
  logic [POS_W-1:0]           pos_r;
  logic [ssc_pkg::DUTY_W-1:0] duty_r, duty_nxt;

  // scan of the byte in the input register
  logic                        full, scan, is_zero, digit, frame_end;
  logic [ssc_pkg::HIST_W-1:0]  shifted;
  logic [ssc_pkg::PROD_W-1:0]  acc;
  ssc_pkg::status_t            status_nxt;

  always_comb begin
    full      = (pos_r == LAST_POS);
    // a full frame ignores this byte and ends regardless of tlast
    frame_end = full || s1_eof_r;
    scan      = !full && !term_r;
    is_zero   = (s1_byte_r == '0);
    digit     = (s1_byte_r >= ssc_pkg::CHAR_ZERO) && (s1_byte_r <= ssc_pkg::CHAR_NINE);
    shifted   = {recent_r[ssc_pkg::HIST_W-ssc_pkg::BYTE_W-1:0], s1_byte_r};
    // value * 10 + digit; low nibble of '0'..'9' is the digit itself
    acc = (ssc_pkg::PROD_W'(num_r) << 3) + (ssc_pkg::PROD_W'(num_r) << 1)
        + ssc_pkg::PROD_W'(s1_byte_r[3:0]);

    recent_nxt = recent_r;
    stop_nxt   = stop_r;
    speed_nxt  = speed_r;
    phase_nxt  = phase_r;
    num_nxt    = num_r;
    term_nxt   = term_r;

    if (scan) begin
      if (is_zero) begin
        // zero byte hides the rest of the frame
        term_nxt = 1'b1;
      end else begin
        recent_nxt = shifted;
        if (shifted[31:0] == ssc_pkg::KEY_STOP || shifted[23:0] == ssc_pkg::KEY_DUR) begin
          stop_nxt = 1'b1;
        end
        if (shifted == ssc_pkg::KEY_SPEED || shifted[23:0] == ssc_pkg::KEY_HIZ) begin
          speed_nxt = 1'b1;
        end
        unique case (phase_r)
          ssc_pkg::NP_NONE: begin
            if (digit) begin
              num_nxt   = ssc_pkg::NUM_W'(s1_byte_r[3:0]);
              phase_nxt = ssc_pkg::NP_RUN;
            end
          end
          ssc_pkg::NP_RUN: begin
            if (digit) begin
              num_nxt = (acc > ssc_pkg::PROD_W'(ssc_pkg::NUM_SAT)) ?
                        ssc_pkg::NUM_SAT : acc[ssc_pkg::NUM_W-1:0];
            end else begin
              phase_nxt = ssc_pkg::NP_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    // frame verdict, from the flags including this byte
    duty_nxt = duty_r;
    priority if (stop_nxt) begin
      duty_nxt   = '0;
      status_nxt = ssc_pkg::ST_STOPPED;
    end else if (speed_nxt) begin
      if (num_nxt <= ssc_pkg::NUM_W'(duty_limit_r)) begin
        duty_nxt   = num_nxt[ssc_pkg::DUTY_W-1:0];
        status_nxt = ssc_pkg::ST_SPEED_SET;
      end else begin
        status_nxt = ssc_pkg::ST_OUT_RANGE;
      end
    end else begin
      status_nxt = ssc_pkg::ST_UNKNOWN;
    end
  end

  // ---------------- result register ----------------
  logic                             out_valid_r;
  logic [ssc_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                             out_free;

  assign out_free = !out_valid_r || out_tready;
  // items that end no frame never wait on the result side
  assign s1_fire  = s1_valid_r && (!frame_end || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= '0;
      stop_r      <= 1'b0;
      speed_r     <= 1'b0;
      phase_r     <= ssc_pkg::NP_NONE;
      num_r       <= '0;
      term_r      <= 1'b0;
      pos_r       <= '0;
      duty_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        if (frame_end) begin
          recent_r <= '0;
          stop_r   <= 1'b0;
          speed_r  <= 1'b0;
          phase_r  <= ssc_pkg::NP_NONE;
          num_r    <= '0;
          term_r   <= 1'b0;
          pos_r    <= '0;
          duty_r   <= duty_nxt;
        end else begin
          recent_r <= recent_nxt;
          stop_r   <= stop_nxt;
          speed_r  <= speed_nxt;
          phase_r  <= phase_nxt;
          num_r    <= num_nxt;
          term_r   <= term_nxt;
          pos_r    <= pos_r + 1'b1;
        end
      end
      if (s1_fire && frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && frame_end) begin
      out_data_r <= {4'b0000, duty_nxt, status_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### src/ssc_checker.sv
// Port-level checker for the serial speed command parser, with its bind.
// Depends on ssc_pkg (status codes); attaches to serial_speed_command_parser_top.
`default_nettype none
module ssc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a stop frame always leaves the duty at zero
  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ssc_pkg::ST_STOPPED |-> out_tdata[11:2] == 10'd0)
    else $error("stop result with nonzero duty");

  // padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'b0000)
    else $error("result padding not zero");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind serial_speed_command_parser_top ssc_checker u_ssc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
